[sv/hct_pkg.sv]
// hct_pkg: shared constants and codes for the hash counting table
// no dependencies
`default_nettype none
package hct_pkg;
  localparam int BUCKETS_DEF       = 1024;
  localparam int MAX_KEY_BYTES_DEF = 32;
  localparam int LANE_SHIFT        = 54;
  localparam int SUB_SIZE          = 256;
  localparam int KEY_W             = 256;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
endpackage
`default_nettype wire

[sv/hct_ram.sv]
// hct_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/hash_counting_table_core.sv]
// hash_counting_table_core: byte-stream key counter on a linear probing table
// depends on hct_pkg and hct_ram
//
// channel | direction | signals
// in      | sink      | in_valid/in_ready: action, data_byte, table_slot, last_byte
// out     | source    | out_valid/out_ready: found, occurrences, slot_index, status
//
// a load beat writes the substitution ram; a key byte is looked up in it, then
// updates the lanes and sum. at a key end comes the hash modulo, then the probe
// walk (ram read, then compare, per bucket visited), then the result; with a bucket
// count not a power of two the modulo takes the sum a byte at a time (quotient, then
// remainder). after reset a clearing pass sweeps the slot ram valid bits; no beat is
// accepted meanwhile. the input also stalls while a result beat is held.
`default_nettype none
module hash_counting_table_core #(
  parameter int BUCKETS       = hct_pkg::BUCKETS_DEF,
  parameter int MAX_KEY_BYTES = hct_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [7:0]  table_slot,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      occurrences,
  output logic [9:0]       slot_index,
  output logic [1:0]       status
);
  localparam int AW  = $clog2(BUCKETS);
  localparam int LW  = $clog2(MAX_KEY_BYTES + 1);
  localparam int KW  = MAX_KEY_BYTES * 8;
  localparam int BIW = $clog2(MAX_KEY_BYTES) > 0 ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int VW  = AW + 1;
  // slot entry: valid, length, key, count
  localparam int EW  = 1 + LW + KW + 32;
  localparam logic [63:0] BMASK = 64'(BUCKETS) - 64'd1;
  // byte-wise modulo: partial remainder and next sum byte, quotient by reciprocal
  localparam int RXW = AW + 8;
  localparam int RS  = RXW + AW;
  localparam logic [63:0] RM = ((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_BYTE, S_MOD, S_RED, S_READ, S_CMP, S_DONE
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  logic [KW-1:0]    key_buf;
  logic [LW-1:0]    key_len;
  logic [7:0]       lane_a, lane_b;
  logic [63:0]      hash_sum;
  logic             overlong;
  logic [1:0]       op;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic [63:0]      rem;
  logic [AW-1:0]    slot;
  logic [VW-1:0]    visited;
  logic [AW-1:0]    red_r;
  logic [7:0]       red_q;
  logic [2:0]       red_k;
  logic             red_ph;
  logic [RXW-1:0]   red_x;
  logic [2*RXW:0]   red_prod;
  logic [RXW-1:0]   red_sub;

  assign red_x    = {red_r, rem[63:56]};
  assign red_prod = (2*RXW+1)'(red_x) * (2*RXW+1)'(RM);
  assign red_sub  = red_x - RXW'(red_q) * RXW'(BUCKETS);

  // substitution ram, two copies so both lanes look up in the same cycle
  logic             sub_we;
  logic [7:0]       sub_a_q, sub_b_q;
  hct_ram #(.WIDTH(8), .DEPTH(hct_pkg::SUB_SIZE)) u_sub_a (
    .clk(clk), .we(sub_we), .waddr(table_slot), .wdata(data_byte),
    .raddr(lane_a ^ data_byte), .rdata(sub_a_q));
  hct_ram #(.WIDTH(8), .DEPTH(hct_pkg::SUB_SIZE)) u_sub_b (
    .clk(clk), .we(sub_we), .waddr(table_slot), .wdata(data_byte),
    .raddr(lane_b ^ data_byte), .rdata(sub_b_q));

  // slot ram
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [EW-1:0]    st_wdata, st_q;
  hct_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_slots (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(slot), .rdata(st_q));

  logic             e_valid;
  logic [LW-1:0]    e_len;
  logic [KW-1:0]    e_key;
  logic [31:0]      e_cnt;
  assign {e_valid, e_len, e_key, e_cnt} = st_q;

  // key compare: unused bytes of the buffer are zero, stored keys likewise
  logic             e_match;
  assign e_match = (e_len == key_len) && (e_key == key_buf);

  logic accept, first_byte, can_add;
  assign in_ready   = (state == S_IDLE) && !(out_valid && !out_ready);
  assign accept     = in_valid && in_ready;
  assign sub_we     = accept && (action == hct_pkg::ACT_LOAD);
  assign first_byte = (key_len == '0);
  assign can_add    = !overlong && (key_len < LW'(MAX_KEY_BYTES));

  logic [31:0] cnt_inc;
  assign cnt_inc = (e_cnt == 32'hFFFF_FFFF) ? e_cnt : e_cnt + 32'd1;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = slot;
    st_wdata = {1'b1, key_len, key_buf, 32'd1};
    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_addr;
      st_wdata = '0;
    end else if (state == S_CMP && op == hct_pkg::ACT_INSERT) begin
      if (!e_valid) begin
        st_we = 1'b1;
      end else if (e_match) begin
        st_we    = 1'b1;
        st_wdata = {1'b1, e_len, e_key, cnt_inc};
      end
    end
  end

  logic [BIW-1:0] bidx;
  assign bidx = BIW'(key_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      key_buf   <= '0;
      key_len   <= '0;
      lane_a    <= '0;
      lane_b    <= '0;
      hash_sum  <= '0;
      overlong  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && (action == hct_pkg::ACT_INSERT ||
                         action == hct_pkg::ACT_SEARCH)) begin
            op       <= action;
            cur_byte <= data_byte;
            cur_last <= last_byte;
            state    <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (!can_add) begin
            overlong <= 1'b1;
          end else begin
            key_buf[bidx*8 +: 8] <= cur_byte;
            key_len <= key_len + LW'(1);
            if (first_byte) begin
              lane_a   <= cur_byte;
              lane_b   <= cur_byte + 8'd1;
              hash_sum <= '0;
            end else begin
              lane_a   <= sub_a_q;
              lane_b   <= sub_b_q;
              hash_sum <= hash_sum + (({56'd0, sub_a_q} << hct_pkg::LANE_SHIFT)
                                      | {56'd0, sub_b_q});
            end
          end
          if (!cur_last) state <= S_IDLE;
          else if (!can_add || overlong) begin
            found <= 1'b0; occurrences <= '0; slot_index <= '0;
            status <= hct_pkg::ST_LONG; out_valid <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // power of two: mask; otherwise reduce the sum a byte at a time, top first
          if ((BUCKETS & (BUCKETS - 1)) == 0) begin
            slot    <= AW'(hash_sum & BMASK);
            visited <= '0;
            state   <= S_READ;
          end else begin
            rem    <= hash_sum;
            red_r  <= '0;
            red_k  <= '0;
            red_ph <= 1'b0;
            state  <= S_RED;
          end
        end
        S_RED: begin
          if (!red_ph) begin
            red_q  <= red_prod[RS +: 8];
            red_ph <= 1'b1;
          end else begin
            red_ph <= 1'b0;
            rem    <= rem << 8;
            red_k  <= red_k + 3'd1;
            red_r  <= red_sub[AW-1:0];
            if (red_k == 3'd7) begin
              slot    <= red_sub[AW-1:0];
              visited <= '0;
              state   <= S_READ;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (!e_valid || e_match) begin
            found       <= e_valid;
            occurrences <= !e_valid ? ((op == hct_pkg::ACT_INSERT) ? 32'd1 : 32'd0)
                         : ((op == hct_pkg::ACT_INSERT) ? cnt_inc : e_cnt);
            slot_index  <= (!e_valid && op != hct_pkg::ACT_INSERT) ? 10'd0
                                                                   : 10'(slot);
            status      <= hct_pkg::ST_OK;
            out_valid   <= 1'b1;
            state       <= S_DONE;
          end else if (visited == VW'(BUCKETS - 1)) begin
            found <= 1'b0; occurrences <= '0; slot_index <= '0;
            status <= (op == hct_pkg::ACT_INSERT) ? hct_pkg::ST_FULL
                                                  : hct_pkg::ST_OK;
            out_valid <= 1'b1;
            state <= S_DONE;
          end else begin
            visited <= visited + VW'(1);
            slot    <= (slot == AW'(BUCKETS - 1)) ? '0 : slot + AW'(1);
            state   <= S_READ;
          end
        end
        S_DONE: begin
          key_buf  <= '0;
          key_len  <= '0;
          lane_a   <= '0;
          lane_b   <= '0;
          hash_sum <= '0;
          overlong <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no result beat is dropped by a new one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result overwritten while stalled");
  // no beat accepted during the clearing pass
  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready)
    else $error("input accepted during clearing pass");
  // a result always follows a compare hit (an empty slot or a matching key)
  a_cmp_result: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP && (!e_valid || e_match) |=> out_valid)
    else $error("probe hit gave no result");
endmodule
`default_nettype wire
